// ----- rtl/core/avf_pkg.sv -----
// Package for the address format validator: character codes, result codes,
// the MAC verdict type and small character-class helpers. No dependencies.
package avf_pkg;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [7:0] V4_GROUPS  = 8'd4;
	localparam logic [7:0] V6_GROUPS  = 8'd8;
	localparam logic [7:0] MAC_GROUPS = 8'd6;
	localparam logic [7:0] SAT_MAX    = 8'd255;

	localparam logic [1:0] KIND_IPV4    = 2'd0;
	localparam logic [1:0] KIND_IPV6    = 2'd1;
	localparam logic [1:0] KIND_MAC     = 2'd2;
	localparam logic [1:0] KIND_NEITHER = 2'd3;

	localparam logic [1:0] FAIL_NONE  = 2'd0;
	localparam logic [1:0] FAIL_LEN   = 2'd1;
	localparam logic [1:0] FAIL_CHAR  = 2'd2;
	localparam logic [1:0] FAIL_COUNT = 2'd3;

	typedef struct packed {
		logic [1:0] code;
		logic [7:0] group;
	} mac_verdict_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic [7:0] inc_sat8(input logic [7:0] v);
		return (v == SAT_MAX) ? v : v + 8'd1;
	endfunction

endpackage

// ----- rtl/core/avf_char_if.sv -----
// Character stream interface: valid/ready handshake carrying one character word.
// Depends on nothing.
interface avf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink (input valid, char_code, last_char, output ready);
endinterface

// ----- rtl/core/avf_result_if.sv -----
// Result stream interface: valid/ready handshake carrying one verdict word.
// Depends on nothing.
interface avf_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] addr_kind;
	logic [1:0] fail_code;
	logic [7:0] fail_group;

	modport source (output valid, addr_kind, fail_code, fail_group, input ready);
	modport sink (input valid, addr_kind, fail_code, fail_group, output ready);
endinterface

// ----- rtl/core/avf_ipv4.sv -----
// IPv4 checker: dotted decimal groups, value 0..255, no leading zero, four groups.
// Depends on avf_pkg.
module avf_ipv4 import avf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       ok
);

	logic       failed_q, lead_q;
	logic [7:0] groups_q, len_q;
	logic [8:0] value_q;

	logic       failed_n, lead_n, final_failed, dec;
	logic [7:0] groups_n, len_n;
	logic [8:0] value_n;
	logic [11:0] prod;

	assign dec  = is_dec(char_code);
	assign prod = {value_q, 3'b000} + {2'b00, value_q, 1'b0} + {8'd0, char_code[3:0]};

	always_comb begin
		failed_n = failed_q;
		lead_n   = lead_q;
		groups_n = groups_q;
		len_n    = len_q;
		value_n  = value_q;
		if (char_code == CH_DOT) begin
			if ((len_q != 8'd0) && ((lead_q && (len_q > 8'd1)) || (value_q > 9'd255)))
				failed_n = 1'b1;
			lead_n  = 1'b0;
			len_n   = 8'd0;
			value_n = 9'd0;
		end else begin
			if (len_q == 8'd0) begin
				groups_n = inc_sat8(groups_q);
				lead_n   = (char_code == CH_ZERO);
			end
			if (!dec)
				failed_n = 1'b1;
			else
				value_n = (prod > 12'd256) ? 9'd256 : prod[8:0];
			len_n = inc_sat8(len_q);
		end
	end

	// Closing the trailing group when the string ends.
	assign final_failed = failed_n ||
		((len_n != 8'd0) && ((lead_n && (len_n > 8'd1)) || (value_n > 9'd255)));
	assign ok = !final_failed && (groups_n == V4_GROUPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			lead_q   <= 1'b0;
			groups_q <= 8'd0;
			len_q    <= 8'd0;
			value_q  <= 9'd0;
		end else if (step) begin
			if (last_char) begin
				failed_q <= 1'b0;
				lead_q   <= 1'b0;
				groups_q <= 8'd0;
				len_q    <= 8'd0;
				value_q  <= 9'd0;
			end else begin
				failed_q <= failed_n;
				lead_q   <= lead_n;
				groups_q <= groups_n;
				len_q    <= len_n;
				value_q  <= value_n;
			end
		end
	end

endmodule

// ----- rtl/core/avf_ipv6.sv -----
// IPv6 checker: colon separated groups of one to four hex digits, eight groups.
// Depends on avf_pkg.
module avf_ipv6 import avf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       ok
);

	logic       failed_q, failed_n;
	logic [7:0] groups_q, groups_n;
	logic [2:0] len_q, len_n;

	always_comb begin
		failed_n = failed_q;
		groups_n = groups_q;
		len_n    = len_q;
		if (char_code == CH_COLON) begin
			len_n = 3'd0;
		end else begin
			if (len_q == 3'd0)
				groups_n = inc_sat8(groups_q);
			if (!is_hex(char_code))
				failed_n = 1'b1;
			if (len_q >= 3'd4)
				failed_n = 1'b1;
			else
				len_n = len_q + 3'd1;
		end
	end

	assign ok = !failed_n && (groups_n == V6_GROUPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			groups_q <= 8'd0;
			len_q    <= 3'd0;
		end else if (step) begin
			if (last_char) begin
				failed_q <= 1'b0;
				groups_q <= 8'd0;
				len_q    <= 3'd0;
			end else begin
				failed_q <= failed_n;
				groups_q <= groups_n;
				len_q    <= len_n;
			end
		end
	end

endmodule

// ----- rtl/core/avf_mac.sv -----
// MAC checker for one separator: six groups of exactly two hex digits.
// Depends on avf_pkg.
module avf_mac import avf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   sep,
	input  logic [7:0]   char_code,
	input  logic         last_char,
	output mac_verdict_t verdict
);

	logic [1:0] code_q, code_n, len_q, len_n;
	logic [7:0] group_q, group_n, groups_q, groups_n;
	logic       bad_q, bad_n;
	mac_verdict_t closed;

	always_comb begin
		code_n   = code_q;
		group_n  = group_q;
		groups_n = groups_q;
		len_n    = len_q;
		bad_n    = bad_q;
		if (char_code == sep) begin
			if ((len_q != 2'd0) && (code_q == FAIL_NONE)) begin
				if (len_q != 2'd2) begin
					code_n  = FAIL_LEN;
					group_n = groups_q;
				end else if (bad_q) begin
					code_n  = FAIL_CHAR;
					group_n = groups_q;
				end
			end
			len_n = 2'd0;
			bad_n = 1'b0;
		end else begin
			if (len_q == 2'd0)
				groups_n = inc_sat8(groups_q);
			if (!is_hex(char_code))
				bad_n = 1'b1;
			if (len_q < 2'd3)
				len_n = len_q + 2'd1;
		end
	end

	// End of string: close the open group, then check the group count.
	always_comb begin
		closed.code  = code_n;
		closed.group = group_n;
		if ((len_n != 2'd0) && (code_n == FAIL_NONE)) begin
			if (len_n != 2'd2) begin
				closed.code  = FAIL_LEN;
				closed.group = groups_n;
			end else if (bad_n) begin
				closed.code  = FAIL_CHAR;
				closed.group = groups_n;
			end
		end
		verdict = closed;
		if ((closed.code == FAIL_NONE) && (groups_n != MAC_GROUPS)) begin
			verdict.code  = FAIL_COUNT;
			verdict.group = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q   <= FAIL_NONE;
			group_q  <= 8'd0;
			groups_q <= 8'd0;
			len_q    <= 2'd0;
			bad_q    <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				code_q   <= FAIL_NONE;
				group_q  <= 8'd0;
				groups_q <= 8'd0;
				len_q    <= 2'd0;
				bad_q    <= 1'b0;
			end else begin
				code_q   <= code_n;
				group_q  <= group_n;
				groups_q <= groups_n;
				len_q    <= len_n;
				bad_q    <= bad_n;
			end
		end
	end

endmodule

// ----- rtl/core/address_format_validator.sv -----
// Address format validator: reads an address string one character word at a
// time and, on the word marked last, reports whether it is IPv4, IPv6, MAC or
// neither, with the MAC checker's failure code and group for neither.
// Depends on avf_pkg, avf_char_if, avf_result_if and the three checker modules.
//
// A character word is taken in every cycle unless the pipeline stalls: it
// lands in an input register, from which the IPv4, IPv6 and both MAC checkers
// update their small counters in a single pass of combinational logic. Only
// the last word of a string produces a result, which is held in an output
// register. The input keeps flowing while a verdict waits to be taken; the
// pipeline stalls only when a last word reaches the checkers and the previous
// verdict is still unclaimed. There is no clearing pass after reset and no
// configuration.
module address_format_validator import avf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	avf_char_if.sink     chars,
	avf_result_if.source verdict
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Output register.
	logic       out_valid_q;
	logic [1:0] kind_q, code_q;
	logic [7:0] group_q;

	logic         saw_dash_q, saw_dash_n;
	logic         advance, step;
	logic         v4_ok, v6_ok;
	mac_verdict_t mac_dash, mac_colon, mac_pick;
	logic [1:0]   kind_n, code_n;
	logic [7:0]   group_n;

	// A word in the input stage may move on unless it ends a string and the
	// output register still holds an untaken verdict.
	assign advance     = !last_s1 || !out_valid_q || verdict.ready;
	assign step        = valid_s1 && advance;
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	avf_ipv4 u_ipv4 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.last_char (last_s1),
		.ok        (v4_ok)
	);

	avf_ipv6 u_ipv6 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.last_char (last_s1),
		.ok        (v6_ok)
	);

	// Both separator choices are tracked at once; the dash wins if any dash
	// appeared anywhere in the string.
	avf_mac u_mac_dash (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.sep       (CH_DASH),
		.char_code (char_s1),
		.last_char (last_s1),
		.verdict   (mac_dash)
	);

	avf_mac u_mac_colon (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.sep       (CH_COLON),
		.char_code (char_s1),
		.last_char (last_s1),
		.verdict   (mac_colon)
	);

	assign saw_dash_n = saw_dash_q || (char_s1 == CH_DASH);
	assign mac_pick   = saw_dash_n ? mac_dash : mac_colon;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_dash_q <= 1'b0;
		end else if (step) begin
			saw_dash_q <= last_s1 ? 1'b0 : saw_dash_n;
		end
	end

	// Priority: IPv4, then IPv6, then MAC; otherwise report the MAC failure.
	always_comb begin
		code_n  = FAIL_NONE;
		group_n = 8'd0;
		if (v4_ok) begin
			kind_n = KIND_IPV4;
		end else if (v6_ok) begin
			kind_n = KIND_IPV6;
		end else if (mac_pick.code == FAIL_NONE) begin
			kind_n = KIND_MAC;
		end else begin
			kind_n  = KIND_NEITHER;
			code_n  = mac_pick.code;
			group_n = mac_pick.group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			kind_q  <= kind_n;
			code_q  <= code_n;
			group_q <= group_n;
		end
	end

	assign verdict.valid      = out_valid_q;
	assign verdict.addr_kind  = kind_q;
	assign verdict.fail_code  = code_q;
	assign verdict.fail_group = group_q;

endmodule

// ----- rtl/core/avf_checker.sv -----
// Port-level checks for the address format validator, and the bind that
// attaches them to the top level. Depends on avf_pkg.
module avf_checker import avf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [1:0] out_code,
	input logic [7:0] out_group
);

	// A verdict that is not taken stays, unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_kind, out_code, out_group}))
		else $error("verdict changed while stalled");

	// Only a string judged neither carries a failure.
	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_NEITHER) |-> (out_code == FAIL_NONE) && (out_group == 8'd0))
		else $error("failure reported for a recognised address");

	// Neither always has a reason; a count failure names no group.
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_NEITHER) |->
			(out_code != FAIL_NONE) && ((out_code != FAIL_COUNT) || (out_group == 8'd0)))
		else $error("inconsistent failure code and group");

	// A fresh verdict follows a word marked last.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("verdict without a last word");

endmodule

bind address_format_validator avf_checker u_avf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last_char),
	.out_valid (verdict.valid),
	.out_ready (verdict.ready),
	.out_kind  (verdict.addr_kind),
	.out_code  (verdict.fail_code),
	.out_group (verdict.fail_group)
);

// ----- tb/tb_address_format_validator.sv -----
// Self-checking testbench for address_format_validator: sends address strings
// a word at a time and checks each verdict against its own checker model.
// Depends on avf_pkg, avf_char_if, avf_result_if and the validator RTL.
module tb_address_format_validator;
	import avf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Bounds of the character classes that the checkers use.
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;

	// Cycles without any handshake before the run is declared hung. The longest
	// honest quiet stretch is the long receiver hold-off.
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 10;
	localparam int RANDOM_WORDS = 200;
	localparam int HOLD_OFF     = 300;
	localparam string HEX_CHARS = "0123456789abcdefABCDEF";
	localparam string NOISE_CHARS = "0123456789abcdefABCDEFgGxz.:-";

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] code;
		logic [7:0] group;
	} verdict_t;

	typedef logic [7:0] text_t[$];

	logic clk;
	logic arst_n;

	avf_char_if   chars_if();
	avf_result_if verdict_if();

	address_format_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.verdict(verdict_if)
	);

	// Verdicts predicted at the moment the last word of a string is accepted,
	// oldest first.
	verdict_t pending_verdicts[$];
	int       mismatches;
	int       words_sent;
	int       hold_cycles;
	int       idle_cycles;
	bit       gaps_on;
	bit       offering;
	int       burst_left;

	// Checker model state. The IPv4 and IPv6 checkers keep a failed flag, a
	// group count and the length of the open group; the MAC checker is kept
	// twice, once for each separator it might turn out to use.
	logic       v4_bad;
	logic [7:0] v4_count;
	logic [7:0] v4_width;
	logic [8:0] v4_num;
	logic       v4_zero_start;
	logic       v6_bad;
	logic [7:0] v6_count;
	logic [2:0] v6_width;
	logic [1:0] mac_code[2];
	logic [7:0] mac_grp[2];
	logic [7:0] mac_count[2];
	logic [1:0] mac_width[2];
	logic       mac_nonhex[2];
	logic       dash_seen;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic is_decimal(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_hexa(input logic [7:0] c);
		return is_decimal(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
	endfunction

	// Counters stick at their top value rather than wrapping.
	function automatic logic [7:0] bump(input logic [7:0] v);
		if (v == 8'hFF)
			return v;
		return v + 8'd1;
	endfunction

	task automatic clear_checkers();
		v4_bad = 1'b0;
		v4_count = '0;
		v4_width = '0;
		v4_num = '0;
		v4_zero_start = 1'b0;
		v6_bad = 1'b0;
		v6_count = '0;
		v6_width = '0;
		for (int k = 0; k < 2; k++) begin
			mac_code[k] = FAIL_NONE;
			mac_grp[k] = '0;
			mac_count[k] = '0;
			mac_width[k] = '0;
			mac_nonhex[k] = 1'b0;
		end
		dash_seen = 1'b0;
	endtask

	// Closing an IPv4 group judges its leading zero and its value; an empty
	// group is simply skipped.
	task automatic close_v4_group();
		if (v4_width != 0) begin
			if (v4_zero_start && v4_width > 1)
				v4_bad = 1'b1;
			if (v4_num > 9'd255)
				v4_bad = 1'b1;
		end
		v4_width = '0;
		v4_num = '0;
		v4_zero_start = 1'b0;
	endtask

	// Only the first failing MAC group is kept; within a group a wrong length
	// is reported in preference to an illegal character.
	task automatic close_mac_group(input int k);
		if (mac_width[k] != 0 && mac_code[k] == FAIL_NONE) begin
			if (mac_width[k] != 2'd2) begin
				mac_code[k] = FAIL_LEN;
				mac_grp[k] = mac_count[k];
			end else if (mac_nonhex[k]) begin
				mac_code[k] = FAIL_CHAR;
				mac_grp[k] = mac_count[k];
			end
		end
		mac_width[k] = '0;
		mac_nonhex[k] = 1'b0;
	endtask

	// Advances all checkers by one character and, on the last character of a
	// string, works out the verdict and returns the checkers to their reset state.
	task automatic classify_char(input logic [7:0] c, input logic last,
		output logic produced, output verdict_t v);
		int unsigned scaled;
		logic [7:0] sep;
		int pick;
		produced = 1'b0;
		v = '0;
		if (c == CH_DASH)
			dash_seen = 1'b1;

		if (c == CH_DOT) begin
			close_v4_group();
		end else begin
			if (v4_width == 0) begin
				v4_count = bump(v4_count);
				v4_zero_start = (c == CH_ZERO);
			end
			if (!is_decimal(c)) begin
				v4_bad = 1'b1;
			end else begin
				scaled = v4_num * 10 + (c - CH_ZERO);
				v4_num = (scaled > 256) ? 9'd256 : scaled[8:0];
			end
			v4_width = bump(v4_width);
		end

		if (c == CH_COLON) begin
			v6_width = '0;
		end else begin
			if (v6_width == 0)
				v6_count = bump(v6_count);
			if (!is_hexa(c))
				v6_bad = 1'b1;
			if (v6_width >= 3'd4)
				v6_bad = 1'b1;
			else
				v6_width = v6_width + 3'd1;
		end

		for (int k = 0; k < 2; k++) begin
			sep = (k == 0) ? CH_DASH : CH_COLON;
			if (c == sep) begin
				close_mac_group(k);
			end else begin
				if (mac_width[k] == 0)
					mac_count[k] = bump(mac_count[k]);
				if (!is_hexa(c))
					mac_nonhex[k] = 1'b1;
				if (mac_width[k] < 2'd3)
					mac_width[k] = mac_width[k] + 2'd1;
			end
		end

		if (last) begin
			close_v4_group();
			for (int k = 0; k < 2; k++) begin
				close_mac_group(k);
				if (mac_code[k] == FAIL_NONE && mac_count[k] != MAC_GROUPS) begin
					mac_code[k] = FAIL_COUNT;
					mac_grp[k] = '0;
				end
			end
			// Any dash anywhere makes the dash the MAC separator.
			pick = dash_seen ? 0 : 1;
			if (!v4_bad && v4_count == V4_GROUPS)
				v.kind = KIND_IPV4;
			else if (!v6_bad && v6_count == V6_GROUPS)
				v.kind = KIND_IPV6;
			else if (mac_code[pick] == FAIL_NONE)
				v.kind = KIND_MAC;
			else begin
				v.kind = KIND_NEITHER;
				v.code = mac_code[pick];
				v.group = mac_grp[pick];
			end
			produced = 1'b1;
			clear_checkers();
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	// Sender pacing: bursts of random length separated by random gaps. While
	// the line is idle the character bus carries rubbish, which must be ignored.
	task automatic pace();
		int gap;
		if (!gaps_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
		chars_if.valid <= 1'b0;
		chars_if.char_code <= 8'($urandom);
		chars_if.last_char <= 1'($urandom);
		offering = 1'b0;
		repeat (gap) @(posedge clk);
		burst_left = $urandom_range(0, 15);
	endtask

	// Offers one word and holds it until the block takes it; the expected
	// verdict, if the word ends a string, is queued at that moment.
	task automatic send_word(input logic [7:0] c, input logic last);
		logic produced;
		verdict_t v;
		chars_if.valid <= 1'b1;
		chars_if.char_code <= c;
		chars_if.last_char <= last;
		offering = 1'b1;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		classify_char(c, last, produced, v);
		if (produced)
			pending_verdicts.push_back(v);
		words_sent++;
		pace();
	endtask

	task automatic send_bytes(input text_t text);
		foreach (text[i])
			send_word(text[i], i == text.size() - 1);
	endtask

	function automatic text_t text_bytes(input string s);
		text_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	task automatic send_text(input string s);
		send_bytes(text_bytes(s));
	endtask

	// Stops offering and waits until every predicted verdict has been seen.
	task automatic wait_drained();
		if (offering) begin
			chars_if.valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: stalls on a pattern that changes every so often, with stretches
	// of no stalling at all, and honours a long hold-off when one is requested.
	// The hold-off is counted down here, independently of the sender.
	initial begin : receiver
		int mode;
		int mode_left;
		int tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		verdict_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_cycles > 0) begin
				verdict_if.ready <= 1'b0;
				hold_cycles--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: verdict_if.ready <= 1'b1;
					1: verdict_if.ready <= 1'($urandom);
					2: verdict_if.ready <= ($urandom_range(0, 7) != 0);
					default: verdict_if.ready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// Every accepted verdict is matched against the oldest prediction.
	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (arst_n && verdict_if.valid && verdict_if.ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict with nothing expected: kind %0d code %0d group %0d",
					verdict_if.addr_kind, verdict_if.fail_code, verdict_if.fail_group));
			end else begin
				want = pending_verdicts.pop_front();
				if (verdict_if.addr_kind !== want.kind)
					report_mismatch($sformatf("addr_kind %0d, expected %0d",
						verdict_if.addr_kind, want.kind));
				if (verdict_if.fail_code !== want.code)
					report_mismatch($sformatf("fail_code %0d, expected %0d",
						verdict_if.fail_code, want.code));
				if (verdict_if.fail_group !== want.group)
					report_mismatch($sformatf("fail_group %0d, expected %0d",
						verdict_if.fail_group, want.group));
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake on either side means
	// the block, or the test, has hung.
	always @(posedge clk) begin
		if ((chars_if.valid && chars_if.ready) || (verdict_if.valid && verdict_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
				IDLE_LIMIT, pending_verdicts.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Well-formed addresses of every kind, including the extremes of the IPv4
	// values and strings whose empty groups must be skipped.
	task automatic test_valid_addresses();
		gaps_on = 1'b1;
		send_text("192.168.1.1");
		send_text("0.0.0.0");
		send_text("255.255.255.255");
		send_text(".1..2.3.4.");
		send_text("2001:db8:85A3:0:0:8a2e:370:7334");
		send_text("FFFF:ffff:0000:1:2:3:4:5");
		send_text("00-1A-2b-3C-4d-5E");
		send_text("00:1a:2b:3c:4d:5e");
		send_text("-00-11--22-33-44-55-");
		wait_drained();
	endtask

	// Each way of failing: IPv4 range, leading zero and count, IPv6 count and
	// group length, and the three MAC errors, including the rule that a length
	// error wins over a bad character in the same group and that a single dash
	// turns a colon-separated string into a dash-separated one.
	task automatic test_malformed_addresses();
		gaps_on = 1'b0;
		send_text("256.1.1.1");
		send_text("01.2.3.4");
		send_text("1.2.3");
		send_text("1.2.3.4.5");
		send_text("1:2:3:4:5:6:7");
		send_text("12345:1:1:1:1:1:1:1");
		send_text("0-11-22-33-44-55");
		send_text("00-11-2G-33-44-55");
		send_text("00-11-2g3-33-44-55");
		send_text("00:11-22:33:44:55");
		send_text("00-11-22-33-44");
		send_text(":::");
		send_text("-");
		send_text("a");
		wait_drained();
	endtask

	// Zero bytes and bytes with the top bit set count as ordinary characters
	// that are neither digits nor hex.
	task automatic test_odd_bytes();
		text_t q;
		gaps_on = 1'b1;
		q = text_bytes("1.2.3.");
		q.push_back(8'h00);
		send_bytes(q);
		q = text_bytes("00-11-22-33-44-5");
		q.push_back(8'hFF);
		send_bytes(q);
		q = text_bytes("1:2:3:4:5:6:7:");
		q.push_back(8'h80);
		send_bytes(q);
		send_word(8'h7F, 1'b1);
		wait_drained();
	endtask

	// One long string of short colon-separated groups: the IPv4 group length
	// and the IPv6 and MAC group counts must stick at their top value. With
	// 264 groups a count that wrapped would land on eight and pass as IPv6.
	task automatic test_saturation();
		text_t q;
		gaps_on = 1'b0;
		q = {};
		repeat (263) q = {q, text_bytes("1:")};
		q.push_back(8'h31);
		send_bytes(q);
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while short strings keep
	// coming, so the block fills and has to stall its input.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_cycles = HOLD_OFF;
		repeat (12) send_text("10.0.0.1");
		wait_drained();
	endtask

	function automatic text_t hex_group(input int width);
		text_t q;
		repeat (width) q.push_back(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)]);
		return q;
	endfunction

	// Builds one candidate address: mostly well-formed addresses of a random
	// kind with random content, sometimes damaged, sometimes plain noise.
	function automatic text_t random_address();
		text_t q;
		int shape;
		int num;
		logic [7:0] sep;
		shape = $urandom_range(0, 9);
		q = {};
		case (shape)
			0, 1: begin
				for (int g = 0; g < 4; g++) begin
					if (g > 0)
						q.push_back(CH_DOT);
					num = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999)
						: $urandom_range(0, 255);
					if ($urandom_range(0, 9) == 0)
						q.push_back(CH_ZERO);
					q = {q, text_bytes($sformatf("%0d", num))};
				end
			end
			2, 3: begin
				for (int g = 0; g < 8; g++) begin
					if (g > 0)
						q.push_back(CH_COLON);
					q = {q, hex_group($urandom_range(1, 4))};
				end
			end
			4, 5, 6: begin
				sep = (shape == 4) ? CH_COLON : CH_DASH;
				for (int g = 0; g < 6; g++) begin
					if (g > 0)
						q.push_back(sep);
					q = {q, hex_group(2)};
				end
			end
			7: begin
				repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
			end
			default: begin
				repeat ($urandom_range(1, 16))
					q.push_back(NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)]);
			end
		endcase
		// Damage a share of the strings: replace, insert, drop or double up.
		if ($urandom_range(0, 9) < 4) begin
			repeat ($urandom_range(1, 2)) begin
				num = $urandom_range(0, q.size() - 1);
				case ($urandom_range(0, 3))
					0: q[num] = NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)];
					1: q.insert(num, NOISE_CHARS[$urandom_range(26, 28)]);
					2: if (q.size() > 1) q.delete(num);
					default: q.insert(num, q[num]);
				endcase
			end
		end
		return q;
	endfunction

	// Random strings until the word budget is spent. Gaps come and go, and
	// now and then the sender waits for every verdict before carrying on.
	task automatic test_random_strings();
		int start;
		int strings;
		start = words_sent;
		strings = 0;
		while (words_sent - start < RANDOM_WORDS) begin
			if (strings % 20 == 0)
				gaps_on = ($urandom_range(0, 4) != 0);
			send_bytes(random_address());
			strings++;
			if ($urandom_range(0, 29) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		mismatches = 0;
		words_sent = 0;
		hold_cycles = 0;
		idle_cycles = 0;
		gaps_on = 1'b0;
		offering = 1'b0;
		burst_left = 0;
		clear_checkers();
		chars_if.valid <= 1'b0;
		chars_if.char_code <= '0;
		chars_if.last_char <= 1'b0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_valid_addresses();
		test_malformed_addresses();
		test_odd_bytes();
		test_saturation();
		test_backpressure();
		test_random_strings();

		// Everything predicted has arrived; keep the clock running so the block can
		// show any verdict that it should not have produced.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/avf_pkg.sv
rtl/core/avf_char_if.sv
rtl/core/avf_result_if.sv
rtl/core/avf_ipv4.sv
rtl/core/avf_ipv6.sv
rtl/core/avf_mac.sv
rtl/core/address_format_validator.sv
rtl/core/avf_checker.sv
tb/tb_address_format_validator.sv
